// ===== sv/fsfc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, character codes and per-character decode functions
// for the fasta sequence stream filter; no dependencies
package fsfc_pkg;

   localparam int LINE_COUNT_BITS  = 32;
   localparam int LINE_NUMBER_BITS = 32;
   localparam int RSP_DEPTH        = 4;
   localparam int RSP_CNT_BITS     = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_UP_A    = 8'h41;
   localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
   localparam logic [7:0] CHAR_LOW_A   = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [1:0] {
      PHASE_START,
      PHASE_IGNORE,
      PHASE_SEQ
   } phase_type;

   typedef enum logic [1:0] {
      KIND_RESIDUE,
      KIND_RECORD,
      KIND_INVALID,
      KIND_NO_HEADER
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
   } result_type;

   typedef struct packed {
      phase_type phase;
      logic      seen_header;
      logic      held_return;
   } line_state_type;

   typedef struct packed {
      logic [1:0]     count;
      result_type     first;
      result_type     second;
      logic           newline;
      line_state_type next;
   } decode_type;

   typedef struct packed {
      kind_type                    kind;
      logic [7:0]                  value;
      logic [LINE_NUMBER_BITS-1:0] line_number;
      logic                        last;
   } rsp_type;

   typedef struct packed {
      logic       emit;
      result_type res;
      phase_type  phase;
      logic       seen_header;
   } char_step_type;

   function automatic char_step_type seq_char(logic [7:0] c, phase_type phase, logic seen);
      logic [7:0]    u;
      char_step_type s;
      s.phase       = phase;
      s.seen_header = seen;
      s.emit        = 1'b0;
      s.res.kind    = KIND_RESIDUE;
      s.res.value   = 8'h00;
      u = c;
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         u = c - CASE_OFFSET;
      end
      if (c == CHAR_SPACE || c == CHAR_TAB) begin
         s.emit = 1'b0;
      end else if ((u >= CHAR_UP_A && u <= CHAR_UP_Z) || u == CHAR_STAR || u == CHAR_DASH) begin
         s.emit      = 1'b1;
         s.res.kind  = KIND_RESIDUE;
         s.res.value = u;
      end else begin
         s.emit      = 1'b1;
         s.res.kind  = KIND_INVALID;
         s.res.value = c;
      end
      return s;
   endfunction

   function automatic char_step_type line_char(logic [7:0] c, phase_type phase, logic seen);
      char_step_type s;
      s.phase       = phase;
      s.seen_header = seen;
      s.emit        = 1'b0;
      s.res.kind    = KIND_RESIDUE;
      s.res.value   = 8'h00;
      unique case (phase)
         PHASE_START: begin
            if (c == CHAR_SEMI) begin
               s.phase = PHASE_IGNORE;
            end else if (c == CHAR_GT) begin
               s.phase       = PHASE_IGNORE;
               s.seen_header = 1'b1;
               s.emit        = 1'b1;
               s.res.kind    = KIND_RECORD;
            end else if (!seen) begin
               s.phase    = PHASE_IGNORE;
               s.emit     = 1'b1;
               s.res.kind = KIND_NO_HEADER;
            end else begin
               s = seq_char(c, PHASE_SEQ, seen);
            end
         end
         PHASE_SEQ: begin
            s = seq_char(c, phase, seen);
         end
         default: begin
            s.emit = 1'b0;
         end
      endcase
      return s;
   endfunction

endpackage

// ===== sv/fsfc_byte_decode.sv =====
`timescale 1ns / 1ps
// per-byte decode: held carriage return, line kind and up to two results
// depends on fsfc_pkg
module fsfc_byte_decode
   import fsfc_pkg::*;
(
   input  logic [7:0]     text_byte,
   input  line_state_type state,
   output decode_type     decode
);

   char_step_type held_step;
   char_step_type byte_step;
   logic          is_return;
   logic          byte_emit;

   always_comb begin
      if (state.held_return) begin
         held_step = line_char(CHAR_RETURN, state.phase, state.seen_header);
      end else begin
         held_step.emit        = 1'b0;
         held_step.res.kind    = KIND_RESIDUE;
         held_step.res.value   = 8'h00;
         held_step.phase       = state.phase;
         held_step.seen_header = state.seen_header;
      end
      byte_step = line_char(text_byte, held_step.phase, held_step.seen_header);
      is_return = (text_byte == CHAR_RETURN);
      byte_emit = byte_step.emit && !is_return;

      decode.newline = (text_byte == CHAR_NEWLINE);
      decode.second  = byte_step.res;
      if (decode.newline) begin
         decode.count            = 2'd0;
         decode.first            = byte_step.res;
         decode.next.phase       = PHASE_START;
         decode.next.seen_header = state.seen_header;
         decode.next.held_return = 1'b0;
      end else begin
         decode.next.held_return = is_return;
         if (is_return) begin
            decode.next.phase       = held_step.phase;
            decode.next.seen_header = held_step.seen_header;
         end else begin
            decode.next.phase       = byte_step.phase;
            decode.next.seen_header = byte_step.seen_header;
         end
         if (held_step.emit) begin
            decode.first = held_step.res;
            decode.count = byte_emit ? 2'd2 : 2'd1;
         end else begin
            decode.first = byte_step.res;
            decode.count = byte_emit ? 2'd1 : 2'd0;
         end
      end
   end

endmodule

// ===== sv/fasta_sequence_stream_filter_core.sv =====
`timescale 1ns / 1ps
// top level of the fasta sequence stream filter: line state, line counter, result queue
// depends on fsfc_pkg and fsfc_byte_decode
//
// Takes FASTA text one byte per transfer and gives residues, record starts and
// warnings, each tagged with the saturating one-based line number and a last flag on
// the final result of its byte. A byte is decoded in the cycle it is taken and its
// zero, one or two results go into a four-entry result queue; rsp_ valid comes from
// the head of that queue. A byte is taken every cycle while the queue holds at most
// two results, so the rate is one byte per cycle, limited only by the result side when
// a held carriage return makes a byte give two results. Results are registered into the queue
// and reach rsp_ once earlier results are taken. No clearing pass is needed after reset.
module fasta_sequence_stream_filter_core
   import fsfc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_text_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_kind,
   output logic [7:0]                  rsp_value,
   output logic [LINE_NUMBER_BITS-1:0] rsp_line_number,
   output logic                        rsp_last
);

   line_state_type             state_ff;
   line_state_type             state_in;
   logic [LINE_COUNT_BITS-1:0] line_count_ff;
   logic [LINE_COUNT_BITS-1:0] line_count_in;
   rsp_type                    queue_ff [RSP_DEPTH];
   rsp_type                    queue_in [RSP_DEPTH];
   logic [RSP_CNT_BITS-1:0]    count_ff;
   logic [RSP_CNT_BITS-1:0]    count_in;

   decode_type                  decode;
   logic                        req_fire;
   logic                        rsp_fire;
   logic [1:0]                  push_n;
   logic [RSP_CNT_BITS-1:0]     base;
   logic [LINE_NUMBER_BITS-1:0] line_number;
   rsp_type                     write0;
   rsp_type                     write1;

   fsfc_byte_decode u_decode (
      .text_byte (req_text_byte),
      .state     (state_ff),
      .decode    (decode)
   );

   assign req_ready = (count_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign rsp_kind        = queue_ff[0].kind;
   assign rsp_value       = queue_ff[0].value;
   assign rsp_line_number = queue_ff[0].line_number;
   assign rsp_last        = queue_ff[0].last;

   // show all ones once the count no longer fits the output field
   assign line_number = ((line_count_ff >> LINE_NUMBER_BITS) != '0) ? '1
                        : LINE_NUMBER_BITS'(line_count_ff);

   assign push_n = req_fire ? decode.count : 2'd0;
   assign base   = count_ff - RSP_CNT_BITS'(rsp_fire);

   always_comb begin
      write0.kind        = decode.first.kind;
      write0.value       = decode.first.value;
      write0.line_number = line_number;
      write0.last        = (decode.count == 2'd1);
      write1.kind        = decode.second.kind;
      write1.value       = decode.second.value;
      write1.line_number = line_number;
      write1.last        = 1'b1;
   end

   always_comb begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         queue_in[i] = queue_ff[i];
      end
      if (rsp_fire) begin
         for (int i = 0; i < RSP_DEPTH - 1; i++) begin
            queue_in[i] = queue_ff[i + 1];
         end
      end
      for (int i = 0; i < RSP_DEPTH; i++) begin
         if (push_n != 2'd0 && base == RSP_CNT_BITS'(i)) begin
            queue_in[i] = write0;
         end
         if (push_n == 2'd2 && base + RSP_CNT_BITS'(1) == RSP_CNT_BITS'(i)) begin
            queue_in[i] = write1;
         end
      end
      count_in = base + RSP_CNT_BITS'(push_n);
   end

   always_comb begin
      state_in      = state_ff;
      line_count_in = line_count_ff;
      if (req_fire) begin
         state_in = decode.next;
         if (decode.newline && line_count_ff != '1) begin
            line_count_in = line_count_ff + LINE_COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PHASE_START;
         state_ff.seen_header <= 1'b0;
         state_ff.held_return <= 1'b0;
         line_count_ff        <= LINE_COUNT_BITS'(1);
         count_ff             <= '0;
      end else begin
         state_ff      <= state_in;
         line_count_ff <= line_count_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_BITS'(RSP_DEPTH))
      else $error("result queue count out of range");

   assert property (@(posedge clock) disable iff (reset)
      line_count_ff != '0)
      else $error("line counter wrapped to zero");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_text_byte == CHAR_NEWLINE
      |=> state_ff.phase == PHASE_START && !state_ff.held_return)
      else $error("newline did not return to line start");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && decode.count != 2'd0 && decode.first.kind == KIND_RECORD
      |=> state_ff.seen_header)
      else $error("record start without header flag");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_text_byte == CHAR_RETURN |=> state_ff.held_return)
      else $error("carriage return not held");

endmodule
